// ===== rtl/core/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg - shared types for the sorted table search block
// Command codes, the queued operation record and the search engine states.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // command codes on the input channel
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // operation kind after classification
    typedef enum logic {
        KIND_WRITE,
        KIND_LOOKUP
    } kind_t;

    // one queued operation
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  slot;
        logic [31:0] address;
        logic [31:0] fixup;
    } op_t;

    // search engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/stbs_front.sv =====
// ----------------------------------------------------------------------------
// stbs_front - input classification and operation queue
// Accepts items, drops writes to slots beyond the table and queues the rest
// in a two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module stbs_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [7:0]        entry_index,
    input  logic [31:0]       address,
    input  logic [31:0]       fixup_value,
    output logic              q_valid,
    output stbs_pkg::op_t     q_head,
    input  logic              q_pop
);

    stbs_pkg::op_t q_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    stbs_pkg::op_t op_in;
    logic          op_keep;
    logic          push;

    // classify the incoming item
    always_comb
    begin
        op_in.slot    = entry_index;
        op_in.address = address;
        op_in.fixup   = fixup_value;
        op_in.kind    = stbs_pkg::KIND_LOOKUP;
        op_keep       = 1'b1;
        unique case (cmd)
            stbs_pkg::CMD_WRITE:
            begin
                op_in.kind = stbs_pkg::KIND_WRITE;
                op_keep    = ({24'd0, entry_index} < 32'(TABLE_DEPTH));
            end
            stbs_pkg::CMD_LOOKUP:
            begin
                op_in.kind = stbs_pkg::KIND_LOOKUP;
                op_keep    = 1'b1;
            end
            default:
            begin
                op_in.kind = stbs_pkg::KIND_LOOKUP;
                op_keep    = 1'b1;
            end
        endcase
    end

    // queue handshake
    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall && op_keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = q_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// ===== rtl/core/stbs_back.sv =====
// ----------------------------------------------------------------------------
// stbs_back - table storage and binary search engine
// Executes queued writes into the key and fixup memories and runs lookups as
// a binary search, one probe per cycle, into a registered result stage.
// ----------------------------------------------------------------------------
module stbs_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  stbs_pkg::op_t     q_head,
    output logic              q_pop,
    input  logic              cfg_valid,
    input  logic [8:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [31:0]       fixup_out
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // table memories
    logic [31:0]       key_mem   [TABLE_DEPTH];
    logic [31:0]       fixup_mem [TABLE_DEPTH];
    logic [31:0]       key_rd_reg;
    logic [31:0]       fix_rd_reg;

    stbs_pkg::state_t  state_reg;
    stbs_pkg::state_t  state_next;

    logic [8:0]        entry_count_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  lo_next;
    logic [CNT_W-1:0]  hie_reg;
    logic [CNT_W-1:0]  hie_next;
    logic [IDX_W-1:0]  mid_reg;
    logic [IDX_W-1:0]  mid_next;
    logic [31:0]       addr_reg;
    logic [31:0]       addr_next;
    logic              res_found_reg;
    logic              res_found_next;
    logic [31:0]       res_fix_reg;
    logic [31:0]       res_fix_next;
    logic              out_valid_reg;
    logic              found_reg;
    logic [31:0]       fixup_out_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              out_load;
    logic              out_free;

    logic [CNT_W-1:0]  used_cnt;
    logic [CNT_W-1:0]  mid_wide;
    logic [CNT_W-1:0]  mid_first;
    logic              key_hit;
    logic              key_less;
    logic [CNT_W-1:0]  lo_upd;
    logic [CNT_W-1:0]  hie_upd;
    logic              range_end;
    logic [CNT_W-1:0]  mid_upd;
    logic              start_lookup;
    logic              start_empty;

    // slots in use, limited to the table depth
    assign used_cnt = ({23'd0, entry_count_reg} > 32'(TABLE_DEPTH)) ?
                      CNT_W'(32'(TABLE_DEPTH)) : CNT_W'({23'd0, entry_count_reg});

    // first probe and probe update
    assign mid_first = (used_cnt - CNT_W'(1)) >> 1;
    assign mid_wide  = CNT_W'(mid_reg);
    assign key_hit   = (key_rd_reg == addr_reg);
    assign key_less  = (key_rd_reg < addr_reg);
    assign lo_upd    = key_less ? (mid_wide + CNT_W'(1)) : lo_reg;
    assign hie_upd   = key_less ? hie_reg : mid_wide;
    assign range_end = (lo_upd >= hie_upd);
    assign mid_upd   = lo_upd + ((hie_upd - lo_upd - CNT_W'(1)) >> 1);

    assign out_free     = !out_valid_reg || !out_stall;
    assign start_lookup = (state_reg == stbs_pkg::ST_IDLE) && q_valid &&
                          (q_head.kind == stbs_pkg::KIND_LOOKUP);
    assign start_empty  = (used_cnt == CNT_W'(0));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (start_lookup)
                begin
                    state_next = start_empty ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE:
            begin
                if (key_hit || range_end)
                begin
                    state_next = stbs_pkg::ST_DONE;
                end
            end
            stbs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = IDX_W'({24'd0, q_head.slot});
        rd_en          = 1'b0;
        rd_addr        = mid_reg;
        lo_next        = lo_reg;
        hie_next       = hie_reg;
        mid_next       = mid_reg;
        addr_next      = addr_reg;
        res_found_next = res_found_reg;
        res_fix_next   = res_fix_reg;
        out_load       = 1'b0;
        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == stbs_pkg::KIND_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        addr_next      = q_head.address;
                        lo_next        = CNT_W'(0);
                        hie_next       = used_cnt;
                        mid_next       = IDX_W'(mid_first);
                        rd_en          = !start_empty;
                        rd_addr        = IDX_W'(mid_first);
                        res_found_next = 1'b0;
                        res_fix_next   = 32'd0;
                    end
                end
            end
            stbs_pkg::ST_PROBE:
            begin
                if (key_hit)
                begin
                    res_found_next = 1'b1;
                    res_fix_next   = fix_rd_reg;
                end
                else if (range_end)
                begin
                    res_found_next = 1'b0;
                    res_fix_next   = 32'd0;
                end
                else
                begin
                    lo_next  = lo_upd;
                    hie_next = hie_upd;
                    mid_next = IDX_W'(mid_upd);
                    rd_en    = 1'b1;
                    rd_addr  = IDX_W'(mid_upd);
                end
            end
            stbs_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= stbs_pkg::ST_IDLE;
            entry_count_reg <= 9'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                entry_count_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // search and result payload
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hie_reg       <= hie_next;
        mid_reg       <= mid_next;
        addr_reg      <= addr_next;
        res_found_reg <= res_found_next;
        res_fix_reg   <= res_fix_next;
        if (out_load)
        begin
            found_reg     <= res_found_reg;
            fixup_out_reg <= res_fix_reg;
        end
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= q_head.address;
            fixup_mem[wr_addr] <= q_head.fixup;
        end
    end

    // memory read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            fix_rd_reg <= fixup_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign fixup_out = fixup_out_reg;

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search - sorted key/fixup table with binary search
// Input items (cmd, entry_index, address, fixup_value) move on in_valid and
// in_stall; an item is taken when in_valid is high and in_stall is low.
// A write (cmd 0) stores a key/fixup pair and gives no result; a lookup
// (cmd 1) gives one result item (found, fixup_out) on out_valid/out_stall.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) sets the number of
// entries in use and is always ready; the user must see that it is written
// only while idle, as the block does not enforce it. Items pass through a
// two-entry queue into the search engine, which makes one memory probe per
// cycle over a single read port of the table. A lookup over n entries takes
// up to floor(log2(n)) + 1 probes; the engine runs it through ST_PROBE (not
// for an empty table) and ST_DONE, taking the next item only once the result
// is loaded. Writes retire at one per cycle while no lookup holds the engine.
// Reset clears the queue, the engine, the result stage and the entry count;
// the table memories keep whatever they held and must be written before use.
// While the receiver stalls, the result stays on the outputs, the engine
// holds a finished result and the queue goes on taking items until full.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  entry_index,
    input  logic [31:0] address,
    input  logic [31:0] fixup_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [31:0] fixup_out
);

    logic          q_valid;
    stbs_pkg::op_t q_head;
    logic          q_pop;

    // the entry count register is always ready for a write
    assign cfg_ready = 1'b1;

    // front: classification and queue
    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .address     (address),
        .fixup_value (fixup_value),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    // back: table memories and search engine
    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .fixup_out (fixup_out)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the sorted key/fixup table with binary search
// Loads sorted tables, sets the entry count through the cfg channel and
// fires lookups at hits, near misses and random addresses. A scoreboard
// class mirrors the table and the fixed probe order, and checks each result
// item against the oldest predicted answer. The input idles and the receiver
// stalls at random in rotating modes.
// ----------------------------------------------------------------------------

// one predicted lookup answer
typedef struct {
    logic        hit;
    logic [31:0] fixup;
} fixup_answer_t;

class fixup_scoreboard;
    logic [31:0]   key_mem [256];
    logic [31:0]   fix_mem [256];
    logic [8:0]    entry_count;
    fixup_answer_t pending_answers [$];
    int            errors;
    int            results_seen;
    int            hits_predicted;

    function new();
        foreach (key_mem[i])
        begin
            key_mem[i] = '0;
            fix_mem[i] = '0;
        end
        entry_count    = '0;
        errors         = 0;
        results_seen   = 0;
        hits_predicted = 0;
    endfunction

    function void set_count(logic [8:0] value);
        entry_count = value;
    endfunction

    // slots actually searched: the count is capped at the table depth
    function int slots_in_use();
        return (int'(entry_count) > 256) ? 256 : int'(entry_count);
    endfunction

    // binary search with the block's fixed probe order
    function fixup_answer_t search_table(logic [31:0] addr);
        fixup_answer_t ans;
        int lo;
        int hi;
        int mid;
        ans.hit   = 1'b0;
        ans.fixup = '0;
        lo = 0;
        hi = slots_in_use() - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (key_mem[mid] == addr)
            begin
                ans.hit   = 1'b1;
                ans.fixup = fix_mem[mid];
                return ans;
            end
            if (key_mem[mid] < addr)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return ans;
    endfunction

    // accepted input item: update the table or queue the lookup answer
    function void note_item(logic cmd_bit, logic [7:0] slot, logic [31:0] addr,
                            logic [31:0] fixv);
        fixup_answer_t ans;
        if (cmd_bit == stbs_pkg::CMD_WRITE)
        begin
            key_mem[slot] = addr;
            fix_mem[slot] = fixv;
        end
        else
        begin
            ans = search_table(addr);
            if (ans.hit)
                hits_predicted++;
            pending_answers.push_back(ans);
        end
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // accepted result item against the oldest answer
    function void check_result(logic got_found, logic [31:0] got_fixup);
        fixup_answer_t exp_ans;
        results_seen++;
        if (pending_answers.size() == 0)
        begin
            report($sformatf("result %0d with nothing pending: found=%0b fixup=%08h",
                             results_seen, got_found, got_fixup));
            return;
        end
        exp_ans = pending_answers.pop_front();
        if (got_found !== exp_ans.hit || got_fixup !== exp_ans.fixup)
            report($sformatf("result %0d: expected %0b/%08h, actual %0b/%08h",
                             results_seen, exp_ans.hit, exp_ans.fixup,
                             got_found, got_fixup));
    endfunction

    function int pending();
        return pending_answers.size();
    endfunction
endclass

module tb_top;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        cmd         = stbs_pkg::CMD_WRITE;
    logic [7:0]  entry_index = '0;
    logic [31:0] address     = '0;
    logic [31:0] fixup_value = '0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data    = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        found;
    logic [31:0] fixup_out;

    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent   = 0;
    int lookups_sent = 0;
    int cfg_writes   = 0;

    fixup_scoreboard sb;

    sorted_table_binary_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .entry_index (entry_index),
        .address     (address),
        .fixup_value (fixup_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .fixup_out   (fixup_out)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // result monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(found, fixup_out);

    // present one item, starting and ending at a falling edge
    task automatic send_item(logic c, logic [7:0] slot, logic [31:0] addr,
                             logic [31:0] fixv);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        entry_index <= slot;
        address     <= addr;
        fixup_value <= fixv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(c, slot, addr, fixv);
        items_sent++;
        if (c == stbs_pkg::CMD_LOOKUP)
            lookups_sent++;
        @(negedge clk);
    endtask

    // lookup with random content in the ignored fields
    task automatic send_lookup(logic [31:0] addr);
        send_item(stbs_pkg::CMD_LOOKUP, 8'($urandom), addr, $urandom);
    endtask

    // hold the sender until every answer is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // write the entry count once the block is idle
    task automatic set_entry_count(logic [8:0] value);
        drain_results();
        // writes give no result, so let any still in flight retire
        repeat (20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_count(value);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // write slots 0..n-1 with non-decreasing keys; dense keys give duplicates
    task automatic load_sorted(int n, bit dense);
        logic [32:0] acc;
        logic [31:0] span;
        logic [31:0] fixv;
        acc  = ($urandom_range(3) == 0) ? 33'd0 : 33'($urandom_range(32'hFFFF));
        span = dense ? 32'd3 : 32'hFFFF_FFFF / n;
        for (int i = 0; i < n; i++)
        begin
            fixv = ($urandom_range(15) == 0) ? 32'd0 : $urandom;
            send_item(stbs_pkg::CMD_WRITE, 8'(i), acc[31:0], fixv);
            if ($urandom_range(7) != 0)
                acc = acc + $urandom_range(span);
            if (acc > 33'hFFFF_FFFF)
                acc = 33'hFFFF_FFFF;
        end
    endtask

    // mostly stored keys, then neighbours and random addresses
    function automatic logic [31:0] pick_address();
        int          lim;
        int          r;
        logic [31:0] k;
        lim = sb.slots_in_use();
        if (lim == 0)
            return $urandom;
        k = sb.key_mem[$urandom_range(lim - 1)];
        r = $urandom_range(99);
        if (r < 70)
            return k;
        else if (r < 80)
            return k + 32'd1;
        else if (r < 90)
            return k - 32'd1;
        return $urandom;
    endfunction

    task automatic run_phase(int p);
        int          n;
        logic [8:0]  count_val;
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 35; stall_pct = 35; end
        endcase
        if (p == 0)
            n = 256;
        else if ($urandom_range(5) == 0)
            n = $urandom_range(64, 256);
        else
            n = $urandom_range(1, 24);
        case (p)
            0: count_val = 9'd256;
            1: count_val = 9'(n);
            2: count_val = 9'd511;
            3: count_val = 9'd1;
            4: count_val = 9'd0;
            5: count_val = 9'(n);
            6: count_val = 9'($urandom_range(511));
            default: count_val = 9'd257;
        endcase
        load_sorted(n, (p % 3) == 0 && p != 0);
        set_entry_count(count_val);
        for (int i = 0; i < 70; i++)
        begin
            if (i == 35)
                drain_results();
            // occasional stray write breaks the ordering
            if ($urandom_range(99) < 8)
                send_item(stbs_pkg::CMD_WRITE, 8'($urandom), $urandom, $urandom);
            else
                send_lookup(pick_address());
        end
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table after reset
        send_lookup(32'd0);
        send_item(stbs_pkg::CMD_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // small table with extreme keys and a zero fixup
        send_item(stbs_pkg::CMD_WRITE, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(stbs_pkg::CMD_WRITE, 8'd1, 32'h0000_0100, 32'h0000_0000);
        send_item(stbs_pkg::CMD_WRITE, 8'd2, 32'h8000_0000, 32'h1234_5678);
        send_item(stbs_pkg::CMD_WRITE, 8'd3, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(stbs_pkg::CMD_WRITE, 8'd255, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
        set_entry_count(9'd4);
        send_item(stbs_pkg::CMD_LOOKUP, 8'h00, 32'h0000_0000, 32'h0000_0000);
        send_lookup(32'h0000_0100);
        send_lookup(32'h8000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_00FF);
        send_lookup(32'h8000_0001);
        send_lookup(32'h7FFF_FFFF);

        // unsorted table with a duplicate key
        send_item(stbs_pkg::CMD_WRITE, 8'd1, 32'hFFFF_FFFF, 32'hAAAA_5555);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_0100);
        send_lookup(32'h0000_0000);

        // random phases, first one fills the whole table
        for (int p = 0; p < 8; p++)
            run_phase(p);

        idle_pct  = 0;
        stall_pct = 0;
        drain_results();
        repeat (20) @(negedge clk);

        $display("covered %0d items (%0d lookups, %0d predicted hits), %0d count writes",
                 items_sent, lookups_sent, sb.hits_predicted, cfg_writes);
        $display("checked %0d result items, %0d failures", sb.results_seen, sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
